// ----- rtl/core/noise_burst_mixer_macros.svh -----
// ---------------------------------------------------------------------------
// Noise burst mixer assertion macros
// Concurrent check wrappers that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef NOISE_BURST_MIXER_MACROS_SVH
`define NOISE_BURST_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define NBM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("noise_burst_mixer check failed");
`define NBM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("noise_burst_mixer check failed");
`else
`define NBM_ASSERT(label, prop)
`define NBM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/nbm_pkg.sv -----
// ---------------------------------------------------------------------------
// Noise burst mixer package
// Slot count, fixed-point constants, command and register codes, state type.
// ---------------------------------------------------------------------------
package nbm_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ACC_W     = 18 + SLOT_W;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 22;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [15:0] AMOUNT_FLOOR   = 16'd6;
	localparam logic [15:0] PICK_MIN_LEVEL = 16'd3277;
	localparam logic [15:0] MIN_LIMIT      = 16'd32;

	localparam logic [15:0] PICK_GAIN    = 16'd26214;
	localparam logic [15:0] SQUEAK_GAIN  = 16'd16384;
	localparam logic [15:0] THUMP_GAIN   = 16'd19661;
	localparam logic [15:0] PICK_DECAY   = 16'd64553;
	localparam logic [15:0] SQUEAK_DECAY = 16'd65012;
	localparam logic [15:0] THUMP_DECAY  = 16'd63570;

	localparam logic [20:0] LCG_MUL = 21'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_PICK   = 2'd1,
		CMD_SQUEAK = 2'd2,
		CMD_THUMP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_ENABLE_MASK   = 3'd0,
		REG_AMOUNT        = 3'd1,
		REG_PICK_LENGTH   = 3'd2,
		REG_SQUEAK_LENGTH = 3'd3,
		REG_THUMP_LENGTH  = 3'd4,
		REG_MAX_LENGTH    = 3'd5,
		REG_NOISE_SEED    = 3'd6
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T_MUL1,
		ST_T_MUL2,
		ST_T_WR,
		ST_CHECK,
		ST_NOISE,
		ST_PROD,
		ST_DECAY,
		ST_FIN
	} state_t;

endpackage

// ----- rtl/core/nbm_mul.sv -----
// ---------------------------------------------------------------------------
// Noise burst mixer multiplier
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module nbm_mul (
	input  logic                                clk,
	input  logic signed [nbm_pkg::MUL_A_W-1:0] a,
	input  logic signed [nbm_pkg::MUL_B_W-1:0] b,
	output logic signed [nbm_pkg::MUL_P_W-1:0] p
);
	import nbm_pkg::*;

	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// ----- rtl/core/noise_burst_mixer.sv -----
// A trigger is accepted, scaled by two multiplies and written to a slot; a tick visits every
// slot, runs noise, product and decay steps for active ones, and skips slots when amount is off.
// Requests are taken one at a time; the single shared multiplier sets the pace.
// A finished result may wait in the output register while the next request is taken.
// Reset (arst_n low, asynchronous) clears all slots and write_slot, restores register
// defaults and loads the noise generator with the default seed of zero.
// ---------------------------------------------------------------------------
// Noise burst mixer
// Mixes decaying filtered noise bursts, held in a ring of slots, into a sample stream.
// ---------------------------------------------------------------------------
`include "noise_burst_mixer_macros.svh"

module noise_burst_mixer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // level [15:0], sample_in [31:16]
	input  logic [1:0]  s_tuser,   // cmd [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // sample_out [15:0]
	output logic        m_tuser,   // clipped [0]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import nbm_pkg::*;

	logic [2:0]  enable_mask_q;
	logic [15:0] amount_q;
	logic [15:0] pick_length_q;
	logic [15:0] squeak_length_q;
	logic [15:0] thump_length_q;
	logic [15:0] max_length_q;
	logic [31:0] noise_q;

	logic [15:0]        amp_q    [NUM_SLOTS];
	logic [15:0]        decay_q  [NUM_SLOTS];
	logic [15:0]        remain_q [NUM_SLOTS];
	logic signed [15:0] filter_q [NUM_SLOTS];
	logic [SLOT_W-1:0]  write_slot_q;
	logic [SLOT_W-1:0]  idx_q;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [15:0]             level_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    out_valid_q;
	logic [15:0]             out_data_q;
	logic                    out_clip_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;

	logic        accept;
	logic        amount_on;
	logic        kind_on;
	logic        slot_busy;
	logic        is_last;
	logic        out_free;
	logic [15:0] level_c;
	logic [15:0] gain_c;
	logic [15:0] decay_c;
	logic [15:0] len_c;
	logic [15:0] limit_c;
	logic [15:0] len_lim;
	logic [SLOT_W-1:0] write_slot_next;

	logic [31:0]        noise_next;
	logic signed [15:0] noise_val;
	logic signed [16:0] filter_sum;
	logic signed [15:0] filter_new;
	logic signed [16:0] contrib;

	nbm_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign accept    = s_tvalid && s_tready;
	assign amount_on = amount_q > AMOUNT_FLOOR;
	assign is_last   = idx_q == SLOT_W'(NUM_SLOTS - 1);
	assign out_free  = !out_valid_q || m_tready;
	assign slot_busy = (NUM_SLOTS == 1) && (remain_q[write_slot_q] != 16'd0);
	assign write_slot_next = (write_slot_q == SLOT_W'(NUM_SLOTS - 1)) ? '0
		: write_slot_q + SLOT_W'(1);

	always_comb begin
		unique case (cmd_t'(s_tuser))
			CMD_PICK:   kind_on = enable_mask_q[0];
			CMD_SQUEAK: kind_on = enable_mask_q[1];
			CMD_THUMP:  kind_on = enable_mask_q[2];
			default:    kind_on = 1'b0;
		endcase
	end

	always_comb begin
		level_c = level_q;
		unique case (cmd_q)
			CMD_PICK: begin
				gain_c  = PICK_GAIN;
				decay_c = PICK_DECAY;
				len_c   = pick_length_q;
				if (level_q < PICK_MIN_LEVEL) begin
					level_c = PICK_MIN_LEVEL;
				end
			end
			CMD_SQUEAK: begin
				gain_c  = SQUEAK_GAIN;
				decay_c = SQUEAK_DECAY;
				len_c   = squeak_length_q;
			end
			default: begin
				gain_c  = THUMP_GAIN;
				decay_c = THUMP_DECAY;
				len_c   = thump_length_q;
			end
		endcase
		limit_c = (max_length_q < MIN_LIMIT) ? MIN_LIMIT : max_length_q;
		len_lim = (len_c > limit_c) ? limit_c : len_c;
	end

	assign noise_next = mul_p[31:0] + LCG_ADD;
	assign noise_val  = {~noise_next[31], noise_next[30:16]};
	assign filter_sum = 17'(filter_q[idx_q]) + 17'(noise_val);
	assign filter_new = filter_sum[16:1];
	assign contrib    = mul_p[32:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					if (cmd_t'(s_tuser) == CMD_TICK) begin
						state_d = amount_on ? ST_CHECK : ST_FIN;
					end else if (kind_on && amount_on && !slot_busy) begin
						state_d = ST_T_MUL1;
					end
				end
			end
			ST_T_MUL1: begin
				mul_a   = MUL_A_W'({1'b0, level_c});
				mul_b   = MUL_B_W'({1'b0, gain_c});
				state_d = ST_T_MUL2;
			end
			ST_T_MUL2: begin
				mul_a   = MUL_A_W'({1'b0, mul_p[31:16]});
				mul_b   = MUL_B_W'({1'b0, amount_q});
				state_d = ST_T_WR;
			end
			ST_T_WR: begin
				state_d = ST_IDLE;
			end
			ST_CHECK: begin
				if (remain_q[idx_q] == 16'd0) begin
					state_d = is_last ? ST_FIN : ST_CHECK;
				end else begin
					mul_a   = MUL_A_W'({1'b0, noise_q});
					mul_b   = MUL_B_W'({1'b0, LCG_MUL});
					state_d = ST_NOISE;
				end
			end
			ST_NOISE: begin
				mul_a   = MUL_A_W'(filter_new);
				mul_b   = MUL_B_W'({1'b0, amp_q[idx_q]});
				state_d = ST_PROD;
			end
			ST_PROD: begin
				mul_a   = MUL_A_W'({1'b0, amp_q[idx_q]});
				mul_b   = MUL_B_W'({1'b0, decay_q[idx_q]});
				state_d = ST_DECAY;
			end
			ST_DECAY: begin
				state_d = is_last ? ST_FIN : ST_CHECK;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q   <= 3'd0;
			amount_q        <= 16'd0;
			pick_length_q   <= 16'd960;
			squeak_length_q <= 16'd2400;
			thump_length_q  <= 16'd1440;
			max_length_q    <= 16'd4096;
			noise_q         <= 32'd0;
		end else begin
			if (state_q == ST_NOISE) begin
				noise_q <= noise_next;
			end
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_ENABLE_MASK:   enable_mask_q   <= cfg_data[2:0];
					REG_AMOUNT:        amount_q        <= cfg_data[15:0];
					REG_PICK_LENGTH:   pick_length_q   <= cfg_data[15:0];
					REG_SQUEAK_LENGTH: squeak_length_q <= cfg_data[15:0];
					REG_THUMP_LENGTH:  thump_length_q  <= cfg_data[15:0];
					REG_MAX_LENGTH:    max_length_q    <= cfg_data[15:0];
					REG_NOISE_SEED:    noise_q         <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				amp_q[i]    <= 16'd0;
				decay_q[i]  <= 16'd0;
				remain_q[i] <= 16'd0;
				filter_q[i] <= 16'sd0;
			end
			write_slot_q <= '0;
			idx_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
				end
				ST_T_WR: begin
					amp_q[write_slot_q]    <= mul_p[31:16];
					decay_q[write_slot_q]  <= decay_c;
					remain_q[write_slot_q] <= len_lim;
					filter_q[write_slot_q] <= 16'sd0;
					write_slot_q           <= write_slot_next;
				end
				ST_CHECK: begin
					if (remain_q[idx_q] == 16'd0 && !is_last) begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				ST_NOISE: begin
					filter_q[idx_q] <= filter_new;
				end
				ST_DECAY: begin
					amp_q[idx_q]    <= mul_p[31:16];
					remain_q[idx_q] <= remain_q[idx_q] - 16'd1;
					if (!is_last) begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(s_tuser);
			level_q <= s_tdata[15:0];
			acc_q   <= ACC_W'($signed(s_tdata[31:16]));
		end else if (state_q == ST_PROD) begin
			acc_q <= acc_q + ACC_W'(contrib);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			if (acc_q > ACC_W'(32767)) begin
				out_data_q <= 16'h7fff;
				out_clip_q <= 1'b1;
			end else if (acc_q < -ACC_W'(32768)) begin
				out_data_q <= 16'h8000;
				out_clip_q <= 1'b1;
			end else begin
				out_data_q <= acc_q[15:0];
				out_clip_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_clip_q;

	`NBM_ASSERT(a_clip_extreme,
		(m_tvalid && m_tuser) |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
	`NBM_ASSERT_NEXT(a_trigger_no_result,
		s_tvalid && s_tready && s_tuser != CMD_TICK, !$rose(m_tvalid))
	`NBM_ASSERT(a_result_from_fin, $rose(m_tvalid) |-> $past(state_q == ST_FIN))

endmodule
